// ----- rtl/fqkd_pkg.sv -----
// shared types and codes for the keyed fifo queue
// no dependencies; imported by fqkd_cell and fifo_queue_with_key_delete_core
package fqkd_pkg;

   localparam int OP_W      = 3;
   localparam int KEY_FIELD_W = 16;
   localparam int WORD_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]        operation;
      logic [KEY_FIELD_W-1:0] key;
      logic [WORD_W-1:0]      salary_bits;
      logic [WORD_W-1:0]      overtime_bits;
   } fqkd_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [KEY_FIELD_W-1:0] found_key;
      logic [WORD_W-1:0]      found_salary;
      logic [WORD_W-1:0]      found_overtime;
      logic [OCC_W-1:0]       occupancy;
   } fqkd_rsp_type;

   // the two payload words of one record
   typedef struct packed {
      logic [WORD_W-1:0] salary;
      logic [WORD_W-1:0] overtime;
   } fqkd_pay_type;

   // per-cell control from the queue sequencer
   typedef struct packed {
      logic capture;    // latch key compare for a new request
      logic occupied;   // cell index is below the entry count
      logic write_new;  // load the request record (tail of the queue)
      logic shift_all;  // take the right neighbor's record
      logic shift_hit;  // take the neighbor's record if at or behind the first hit
   } fqkd_cell_cmd_type;

endpackage

// ----- rtl/fqkd_cell.sv -----
// one queue slot: record storage, key compare and first-hit chain link
// depends on fqkd_pkg
module fqkd_cell #(
   parameter int KEY_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fqkd_pkg::fqkd_cell_cmd_type cmd,
   input  logic [KEY_BITS-1:0]        cmp_key,
   input  logic [KEY_BITS-1:0]        new_key,
   input  fqkd_pkg::fqkd_pay_type     new_pay,
   input  logic [KEY_BITS-1:0]        nbr_key,
   input  fqkd_pkg::fqkd_pay_type     nbr_pay,
   input  logic                       hit_before,
   output logic                       hit_through,
   output logic                       sel,
   output logic [KEY_BITS-1:0]        key_q,
   output fqkd_pkg::fqkd_pay_type     pay_q
);
   import fqkd_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   fqkd_pay_type        pay_ff;
   logic                hit_ff;
   logic                shift;

   assign hit_through = hit_before | hit_ff;
   assign sel         = hit_ff & ~hit_before;
   // a dequeue shifts every slot; a delete closes up every slot from the first match toward the tail
   assign shift       = cmd.shift_all | (cmd.shift_hit & hit_through);
   assign key_q       = key_ff;
   assign pay_q       = pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.capture) begin
         hit_ff <= cmd.occupied & (key_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         key_ff <= new_key;
         pay_ff <= new_pay;
      end else if (shift) begin
         key_ff <= nbr_key;
         pay_ff <= nbr_pay;
      end
   end

endmodule

// ----- rtl/fifo_queue_with_key_delete_core.sv -----
// Keyed FIFO queue of records (key, salary word, overtime word) held in a row of
// QUEUE_DEPTH slots, slot 0 at the head. A request is taken when start is high and
// busy is low; busy is then high while it executes, and the result appears with
// rsp_strobe in the cycle after that, and a new request can be taken as soon as busy
// is low again. The key compare of all slots is registered at the accepting edge;
// the edge at which busy is high applies the enqueue write, the one-step shift that
// closes up a dequeue or delete, and registers the result. The result is shown for
// exactly one cycle; there is no way to hold it off. Only the low KEY_BITS bits of
// a key are stored and compared (the smaller of KEY_WIDTH and KEY_FIELD_W).
// depends on fqkd_pkg and fqkd_cell
module fifo_queue_with_key_delete_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_WIDTH   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fqkd_pkg::fqkd_req_type req,
   output logic                  rsp_strobe,
   output fqkd_pkg::fqkd_rsp_type rsp
);
   import fqkd_pkg::*;

   localparam int KEY_BITS = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

   logic              busy_ff;
   fqkd_req_type      req_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_strobe_ff;
   fqkd_rsp_type      rsp_ff, rsp_in;

   logic                accept;
   logic                enq_go, deq_go, del_go;
   logic                full, empty, any_hit;
   logic [QUEUE_DEPTH:0] hit_chain;
   logic [QUEUE_DEPTH-1:0] sel;
   logic [KEY_BITS-1:0] key_q [QUEUE_DEPTH];
   fqkd_pay_type        pay_q [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] sel_key;
   fqkd_pay_type        sel_pay;
   fqkd_pay_type        req_pay;

   assign accept  = start & ~busy_ff;
   assign busy    = busy_ff;
   assign req_pay = '{salary: req_ff.salary_bits, overtime: req_ff.overtime_bits};

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      fqkd_cell_cmd_type cmd;
      logic [KEY_BITS-1:0] nbr_key;
      fqkd_pay_type        nbr_pay;

      always_comb begin
         cmd.capture   = accept;
         cmd.occupied  = (CNT_W'(i) < count_ff);
         cmd.write_new = busy_ff & enq_go & (count_ff == CNT_W'(i));
         cmd.shift_all = busy_ff & deq_go;
         cmd.shift_hit = busy_ff & del_go;
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nbr_key = '0;
         assign nbr_pay = '0;
      end else begin : g_mid
         assign nbr_key = key_q[i+1];
         assign nbr_pay = pay_q[i+1];
      end

      fqkd_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .cmp_key     (req.key[KEY_BITS-1:0]),
         .new_key     (req_ff.key[KEY_BITS-1:0]),
         .new_pay     (req_pay),
         .nbr_key     (nbr_key),
         .nbr_pay     (nbr_pay),
         .hit_before  (hit_chain[i]),
         .hit_through (hit_chain[i+1]),
         .sel         (sel[i]),
         .key_q       (key_q[i]),
         .pay_q       (pay_q[i])
      );
   end

   // at most one slot has sel set, so an or of the gated records picks it
   always_comb begin
      sel_key = '0;
      sel_pay = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_key = sel_key | (key_q[i] & {KEY_BITS{sel[i]}});
         sel_pay = sel_pay | (pay_q[i] & {(2*WORD_W){sel[i]}});
      end
   end

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign any_hit = hit_chain[QUEUE_DEPTH];

   always_comb begin
      enq_go   = 1'b0;
      deq_go   = 1'b0;
      del_go   = 1'b0;
      count_in = count_ff;
      rsp_in   = '0;
      rsp_in.status = ST_OK;
      case (req_ff.operation)
         OP_ENQUEUE: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               enq_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DEQUEUE: begin
            if (empty) begin
               rsp_in.status = ST_MISS;
            end else begin
               deq_go                = 1'b1;
               count_in              = count_ff - CNT_W'(1);
               rsp_in.found_key      = KEY_FIELD_W'(key_q[0]);
               rsp_in.found_salary   = pay_q[0].salary;
               rsp_in.found_overtime = pay_q[0].overtime;
            end
         end
         OP_SEARCH: begin
            if (any_hit) begin
               rsp_in.found_key      = KEY_FIELD_W'(sel_key);
               rsp_in.found_salary   = sel_pay.salary;
               rsp_in.found_overtime = sel_pay.overtime;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         OP_DELETE: begin
            if (any_hit) begin
               del_go   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            rsp_in.status = ST_MISS;
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= accept;
         rsp_strobe_ff <= busy_ff;
         if (busy_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // busy never stays high past the execute step of a request
   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held longer than one cycle");

   // a result follows every execute cycle and nothing else
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(busy_ff))
      else $error("result strobe not tied to an executed request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // reported occupancy matches the count left behind
   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.occupancy == OCC_W'(count_ff)))
      else $error("occupancy differs from entry count");

   a_full_on_enq: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp.status == ST_FULL)) |->
         ((req_ff.operation == OP_ENQUEUE) && (count_ff == CNT_W'(QUEUE_DEPTH))))
      else $error("full status outside a refused enqueue");

endmodule
